[sv/pen_pkg.sv]
// Shared types and constants for the peak envelope normalizer.
`timescale 1ns / 1ps

package pen_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 24;
    localparam int INDEX_W     = 6;
    localparam int LEVEL_W     = 16;
    localparam int DIV_STEPS   = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                wr_bin;
        logic                clip_end;
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] global_peak;
    } entry_t;

endpackage

[sv/pen_ifs.sv]
// Stream interfaces for sample input beats and level output beats.
`timescale 1ns / 1ps

interface pen_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface pen_level_if;
    logic        valid;
    logic        ready;
    logic [5:0]  bin_index;
    logic [15:0] level;
    logic        last_bin;

    modport source (output valid, output bin_index, output level, output last_bin,
                    input ready);
    modport sink (input valid, input bin_index, input level, input last_bin,
                  output ready);
endinterface

[sv/pen_front.sv]
// Front end: frame/bin counting, running bin peak and clip peak, queue pushes.
`timescale 1ns / 1ps

module pen_front #(
    parameter int BINS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pen_pkg::COUNT_W-1:0]       cfg_data,
    pen_sample_if.sink                        samples,
    output logic                              push,
    output pen_pkg::entry_t                   push_entry,
    input  logic                              full
);

    localparam int CBW = $clog2(BINS + 1);
    localparam int MW  = pen_pkg::COUNT_W + 1 + $clog2(BINS + 1);

    logic [pen_pkg::COUNT_W-1:0]  frame_count_reg;
    logic [pen_pkg::SAMPLE_W-1:0] cur_peak_reg, cur_peak_next;
    logic [pen_pkg::SAMPLE_W-1:0] gpeak_reg, gpeak_next;
    logic [pen_pkg::COUNT_W-1:0]  fs_reg, fs_next;
    logic [pen_pkg::COUNT_W-1:0]  fib_reg, fib_next;
    logic [CBW-1:0]               cb_reg, cb_next;

    logic                         accept;
    logic [pen_pkg::SAMPLE_W-1:0] raw;
    logic [pen_pkg::SAMPLE_W-1:0] mag;
    logic                         cb_open;
    logic                         counted;
    logic [pen_pkg::SAMPLE_W-1:0] peak_upd;
    logic [pen_pkg::SAMPLE_W-1:0] gpeak_upd;
    logic [pen_pkg::COUNT_W-1:0]  fs_inc;
    logic [pen_pkg::COUNT_W:0]    fib_inc;
    logic [MW-1:0]                scaled;
    logic                         clip_end;
    logic                         advance;

    assign samples.ready = !full;
    assign accept        = samples.valid && !full;

    assign raw = samples.sample;
    assign mag = raw[pen_pkg::SAMPLE_W-1] ? (~raw + 16'd1) : raw;

    assign cb_open   = cb_reg < CBW'(BINS);
    assign counted   = (frame_count_reg >= pen_pkg::COUNT_W'(BINS)) && cb_open;
    assign peak_upd  = (counted && (mag > cur_peak_reg)) ? mag : cur_peak_reg;
    assign gpeak_upd = (counted && (mag > gpeak_reg)) ? mag : gpeak_reg;

    assign fs_inc   = fs_reg + 24'd1;
    assign fib_inc  = {1'b0, fib_reg} + 25'd1;
    // bin is full when fc < (frames_in_bin + 1) * BINS
    assign scaled   = MW'(fib_inc + 25'd1) * MW'(BINS);
    assign clip_end = samples.frame_end && (fs_inc >= frame_count_reg);
    assign advance  = samples.frame_end && counted && (MW'(frame_count_reg) < scaled);

    assign push                   = accept && (clip_end || advance);
    assign push_entry.wr_bin      = cb_open && (clip_end || advance);
    assign push_entry.clip_end    = clip_end;
    assign push_entry.peak        = peak_upd;
    assign push_entry.global_peak = gpeak_upd;

    always_comb
    begin
        cur_peak_next = cur_peak_reg;
        gpeak_next    = gpeak_reg;
        fs_next       = fs_reg;
        fib_next      = fib_reg;
        cb_next       = cb_reg;
        if (accept)
        begin
            cur_peak_next = peak_upd;
            gpeak_next    = gpeak_upd;
            if (samples.frame_end)
            begin
                fs_next = fs_inc;
                if (counted)
                begin
                    if (advance)
                    begin
                        fib_next      = '0;
                        cb_next       = cb_reg + CBW'(1);
                        cur_peak_next = '0;
                    end
                    else
                    begin
                        fib_next = fib_inc[pen_pkg::COUNT_W-1:0];
                    end
                end
            end
            if (clip_end)
            begin
                cur_peak_next = '0;
                gpeak_next    = '0;
                fs_next       = '0;
                fib_next      = '0;
                cb_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            cur_peak_reg    <= '0;
            gpeak_reg       <= '0;
            fs_reg          <= '0;
            fib_reg         <= '0;
            cb_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                frame_count_reg <= cfg_data;
            end
            cur_peak_reg <= cur_peak_next;
            gpeak_reg    <= gpeak_next;
            fs_reg       <= fs_next;
            fib_reg      <= fib_next;
            cb_reg       <= cb_next;
        end
    end

endmodule

[sv/pen_queue.sv]
// Short FIFO of bin-close and clip-end entries between front and back.
`timescale 1ns / 1ps

module pen_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pen_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output pen_pkg::entry_t pop_entry,
    output logic            empty
);

    localparam int PW = $clog2(pen_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(pen_pkg::QUEUE_DEPTH + 1);

    pen_pkg::entry_t slots_reg [pen_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = count_reg == NW'(pen_pkg::QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/pen_back.sv]
// Back end: bin peak store, serial divider and level output register.
`timescale 1ns / 1ps

module pen_back #(
    parameter int BINS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    output logic            pop,
    input  pen_pkg::entry_t pop_entry,
    input  logic            empty,
    pen_level_if.source     levels
);

    localparam int AW = $clog2(BINS);
    localparam int FW = $clog2(BINS + 1);
    localparam int CW = $clog2(pen_pkg::DIV_STEPS);
    localparam int SW = pen_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        ST_POP,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [SW-1:0]               mem [BINS];
    logic [SW-1:0]               rd_data_reg;
    logic [FW-1:0]               fill_reg;
    logic [AW-1:0]               k_reg;
    logic [SW-1:0]               gpeak_reg;
    logic [SW-1:0]               rem_reg;
    logic [SW-1:0]               low_reg;
    logic [pen_pkg::LEVEL_W-1:0] quot_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        out_valid_reg;
    logic [pen_pkg::INDEX_W-1:0] out_index_reg;
    logic [pen_pkg::LEVEL_W-1:0] out_level_reg;
    logic                        out_last_reg;

    logic                        wr_en;
    logic [SW-1:0]               peak;
    logic [2*SW-1:0]             num;
    logic [SW:0]                 trial;
    logic                        ge;
    logic                        last_k;
    logic                        out_free;
    logic                        load_out;

    assign pop      = (state_reg == ST_POP) && !empty;
    assign wr_en    = pop && pop_entry.wr_bin;
    assign peak     = (FW'(k_reg) < fill_reg) ? rd_data_reg : '0;
    // (peak * 32768 + gp / 2), quotient fits 16 bits since peak <= gp
    assign num      = ((2*SW)'(peak) << 15) + (2*SW)'(gpeak_reg >> 1);
    assign trial    = {rem_reg, low_reg[SW-1]};
    assign ge       = trial >= {1'b0, gpeak_reg};
    assign last_k   = k_reg == AW'(BINS - 1);
    assign out_free = !out_valid_reg || levels.ready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    assign levels.valid     = out_valid_reg;
    assign levels.bin_index = out_index_reg;
    assign levels.level     = out_level_reg;
    assign levels.last_bin  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= pop_entry.peak;
        end
        rd_data_reg <= mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_POP;
            fill_reg      <= '0;
            k_reg         <= '0;
            gpeak_reg     <= '0;
            rem_reg       <= '0;
            low_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_level_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && levels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_POP:
                begin
                    if (pop)
                    begin
                        if (pop_entry.wr_bin)
                        begin
                            fill_reg <= fill_reg + FW'(1);
                        end
                        if (pop_entry.clip_end)
                        begin
                            gpeak_reg <= pop_entry.global_peak;
                            k_reg     <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    quot_reg <= '0;
                    cnt_reg  <= '0;
                    rem_reg  <= num[2*SW-1:SW];
                    low_reg  <= num[SW-1:0];
                    if (gpeak_reg == '0)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= ge ? SW'(trial - {1'b0, gpeak_reg}) : trial[SW-1:0];
                    low_reg  <= low_reg << 1;
                    quot_reg <= {quot_reg[pen_pkg::LEVEL_W-2:0], ge};
                    cnt_reg  <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(pen_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_index_reg <= pen_pkg::INDEX_W'(k_reg);
                        out_level_reg <= quot_reg;
                        out_last_reg  <= last_k;
                        if (last_k)
                        begin
                            fill_reg  <= '0;
                            state_reg <= ST_POP;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_POP;
                end
            endcase
        end
    end

endmodule

[sv/peak_envelope_normalizer.sv]
// Top level of the peak envelope normalizer.
//
// samples: one signed Q1.15 sample per beat, the channels of a frame in
// turn, frame_end set on the frame's last channel. cfg_write/cfg_data load
// frame_count (frames per clip); the user must do so only while the block
// is idle, as the block does not enforce it. The clip is cut into BINS
// bins of frame_count / BINS frames; each bin keeps its largest |sample|,
// tail frames are dropped. levels: at the frame_end that closes the clip,
// BINS beats follow in bin order, level = bin peak / clip peak with
// 32768 = 1.0, last_bin on the final one. All levels are zero for a short
// or silent clip. Samples are taken one per cycle while the queue is not
// full. Each level passes through the back end in turn: store read, load,
// 16-step serial divider, output load (the divider is skipped when the
// clip peak is zero). The next clip streams in meanwhile until the 4-entry
// queue between front and back fills, then samples stall.
// A stalled levels receiver holds the output register and the drain.
// Reset clears frame_count, all counters and the queue; no clearing pass.
`timescale 1ns / 1ps

module peak_envelope_normalizer #(
    parameter int BINS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [pen_pkg::COUNT_W-1:0] cfg_data,
    pen_sample_if.sink                  samples,
    pen_level_if.source                 levels
);

    logic            push;
    pen_pkg::entry_t push_entry;
    logic            full;
    logic            pop;
    pen_pkg::entry_t pop_entry;
    logic            empty;

    pen_front #(
        .BINS (BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .samples    (samples),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    pen_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    pen_back #(
        .BINS (BINS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_entry (pop_entry),
        .empty     (empty),
        .levels    (levels)
    );

endmodule

[dv/testbench.sv]
// Self-checking testbench for peak_envelope_normalizer: predicts normalized bin levels per clip.
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_W      = pen_pkg::SAMPLE_W;
    localparam int COUNT_W       = pen_pkg::COUNT_W;
    localparam int INDEX_W       = pen_pkg::INDEX_W;
    localparam int LEVEL_W       = pen_pkg::LEVEL_W;
    localparam int BINS          = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 60;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_BEATS  = 340;

    typedef struct packed {
        logic [INDEX_W-1:0] bin_index;
        logic [LEVEL_W-1:0] level;
        logic               last_bin;
    } level_beat_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [COUNT_W-1:0] cfg_data;

    pen_sample_if samples_if();
    pen_level_if  levels_if();

    peak_envelope_normalizer #(
        .BINS(BINS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data),
        .samples  (samples_if),
        .levels   (levels_if)
    );

    // predictor state
    logic [COUNT_W-1:0]  fc_model;
    logic [SAMPLE_W-1:0] peak_store [BINS];
    logic [SAMPLE_W-1:0] clip_peak;
    logic [COUNT_W-1:0]  frames_done;
    logic [COUNT_W-1:0]  bin_frames;
    int                  filling_bin;

    level_beat_t pending_levels[$];
    int          fail_count;
    int          beats_sent;
    int          idle_cycles;
    int          rx_stall;
    bit          tx_steady;
    bit          rx_steady;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_clip_model();
        for (int k = 0; k < BINS; k++)
            peak_store[k] = '0;
        clip_peak   = '0;
        frames_done = '0;
        bin_frames  = '0;
        filling_bin = 0;
    endfunction

    function automatic void predict_levels(logic signed [SAMPLE_W-1:0] value,
                                           logic last_channel);
        logic [SAMPLE_W-1:0] mag;
        logic [COUNT_W-1:0]  per;
        longint unsigned     num;
        level_beat_t         beat;
        mag = (value < 0) ? SAMPLE_W'(-int'(value)) : SAMPLE_W'(value);
        per = COUNT_W'(fc_model / BINS);
        if (per != 0 && filling_bin < BINS)
        begin
            if (mag > peak_store[filling_bin])
                peak_store[filling_bin] = mag;
            if (mag > clip_peak)
                clip_peak = mag;
        end
        if (!last_channel)
            return;
        frames_done = frames_done + 1'b1;
        if (per != 0 && filling_bin < BINS)
        begin
            bin_frames = bin_frames + 1'b1;
            if (bin_frames >= per)
            begin
                bin_frames = '0;
                filling_bin++;
            end
        end
        if (frames_done < fc_model)
            return;
        for (int k = 0; k < BINS; k++)
        begin
            beat.bin_index = INDEX_W'(k);
            beat.level     = '0;
            if (clip_peak != 0)
            begin
                num = 64'(peak_store[k]) * 64'd32768 + 64'(clip_peak >> 1);
                beat.level = LEVEL_W'(num / 64'(clip_peak));
            end
            beat.last_bin = (k == BINS - 1);
            pending_levels = {pending_levels, beat};
        end
        clear_clip_model();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int amp);
        int r;
        int v;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        if (r < 3)
            return SAMPLE_W'($urandom);
        v = int'($urandom_range(0, 2 * amp)) - amp;
        return v[SAMPLE_W-1:0];
    endfunction

    // call at a rising edge; leaves valid high after the beat is taken
    task automatic send_beat(input logic signed [SAMPLE_W-1:0] value,
                             input logic last_channel);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid     <= 1'b1;
        samples_if.sample    <= value;
        samples_if.frame_end <= last_channel;
        do @(posedge clk); while (!samples_if.ready);
        predict_levels(value, last_channel);
        beats_sent++;
    endtask

    task automatic send_frame(input int channels, input int amp);
        for (int c = 0; c < channels; c++)
            send_beat(pick_sample(amp), c == channels - 1);
    endtask

    task automatic wait_drained();
        samples_if.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_count(input logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        fc_model = value;
    endtask

    // frame_count 0 closes at the first frame; a short clip counts nothing
    task automatic test_short_clips();
        set_frame_count('0);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh8000, 1'b1);
        set_frame_count(24'd5);
        for (int f = 0; f < 5; f++)
            send_frame(2, 32767);
    endtask

    // largest count, then lowered mid-clip so the next frame end closes it
    task automatic test_lowered_count();
        set_frame_count(24'hFFFFFF);
        send_beat(16'sh0001, 1'b1);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b1);
        send_beat(16'sh5555, 1'b0);
        send_beat(-16'sh5556, 1'b1);
        send_beat(-16'sd1, 1'b1);
        set_frame_count(24'd1);
        send_beat(16'sh2AAA, 1'b1);
    endtask

    task automatic test_silent_clip();
        set_frame_count(24'h800000);
        send_beat(16'sh0000, 1'b0);
        send_beat(16'sh0000, 1'b1);
        send_beat(16'sh0000, 1'b1);
        set_frame_count('0);
        send_beat(16'sh7FFF, 1'b1);
    endtask

    task automatic test_random_clips();
        int start;
        int fc;
        int frames;
        int amp;
        int seen;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            amp = $urandom_range(1, 32767);
            case ($urandom_range(0, 9))
                0:
                begin
                    fc = $urandom_range(0, 63);
                    set_frame_count(COUNT_W'(fc));
                    frames = (fc == 0) ? 1 : fc;
                    for (int f = 0; f < frames; f++)
                        send_frame($urandom_range(1, 2), amp);
                end
                1:
                begin
                    fc = $urandom_range(64, 80);
                    set_frame_count(COUNT_W'(fc));
                    for (int f = 0; f < fc; f++)
                        send_frame(1, 0);
                end
                2, 3:
                begin
                    fc = $urandom_range(64, 24'hFFFFFF);
                    set_frame_count(COUNT_W'(fc));
                    seen = $urandom_range(1, 20);
                    for (int f = 0; f < seen; f++)
                        send_frame($urandom_range(1, 2), amp);
                    set_frame_count(COUNT_W'($urandom_range(0, seen)));
                    send_frame($urandom_range(1, 2), amp);
                end
                default:
                begin
                    fc = ($urandom_range(0, 3) == 0) ? $urandom_range(91, 200)
                                                     : $urandom_range(64, 90);
                    set_frame_count(COUNT_W'(fc));
                    for (int f = 0; f < fc; f++)
                        send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1,
                                   amp);
                end
            endcase
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // level receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            levels_if.ready <= 1'b0;
        end
        else if (rx_steady)
        begin
            rx_stall = 0;
            levels_if.ready <= 1'b1;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            levels_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            rx_stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 2);
            levels_if.ready <= 1'b0;
        end
        else
        begin
            levels_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_levels
        level_beat_t want;
        if (rst_n && levels_if.valid && levels_if.ready)
        begin
            if (pending_levels.size() == 0)
            begin
                $error("unexpected level beat: bin_index %0d level %0d last_bin %0d",
                       levels_if.bin_index, levels_if.level, levels_if.last_bin);
                fail_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (levels_if.bin_index !== want.bin_index)
                begin
                    $error("bin_index: expected %0d, got %0d", want.bin_index,
                           levels_if.bin_index);
                    fail_count++;
                end
                if (levels_if.level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, levels_if.level);
                    fail_count++;
                end
                if (levels_if.last_bin !== want.last_bin)
                begin
                    $error("last_bin: expected %0d, got %0d", want.last_bin,
                           levels_if.last_bin);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_if.valid && samples_if.ready) || (levels_if.valid && levels_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count  = 0;
        beats_sent  = 0;
        idle_cycles = 0;
        rx_stall    = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        fc_model    = '0;
        clear_clip_model();
        rst_n                <= 1'b0;
        cfg_write            <= 1'b0;
        cfg_data             <= '0;
        samples_if.valid     <= 1'b0;
        samples_if.sample    <= '0;
        samples_if.frame_end <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_clips();
        test_lowered_count();
        test_silent_clip();
        test_random_clips();

        samples_if.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[peak_envelope_normalizer.f]
sv/pen_pkg.sv
sv/pen_ifs.sv
sv/pen_front.sv
sv/pen_queue.sv
sv/pen_back.sv
sv/peak_envelope_normalizer.sv
dv/testbench.sv
